// File: sv/tpsa_pkg.sv
// shared types and constants of the tensor pad source address core
// no dependencies; used by tensor_pad_source_address_core
`default_nettype none

package tpsa_pkg;

  localparam int NumDim = 3;
  localparam int CoordW = 14;
  localparam int DimW = 13;
  localparam int AddrW = 36;
  localparam int ModeW = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 13;
  localparam int MaxDimDefault = 4096;

  // signed working width for mirrored coordinates
  localparam int RelW = 17;
  // width of the partial address (c0 * size1 + c1)
  localparam int RowW = 2 * DimW;

  localparam logic [ModeW-1:0] ModeConst = 2'd0;
  localparam logic [ModeW-1:0] ModeEdge = 2'd1;
  localparam logic [ModeW-1:0] ModeReflect = 2'd2;
  localparam logic [ModeW-1:0] ModeSymmetric = 2'd3;

  localparam logic [CfgIdxW-1:0] RegPadMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSrcSize0 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSrcSize1 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSrcSize2 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPadBegin0 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPadBegin1 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPadBegin2 = 3'd6;

  typedef struct packed {
    logic [CoordW-1:0] dst_coord_0;
    logic [CoordW-1:0] dst_coord_1;
    logic [CoordW-1:0] dst_coord_2;
  } in_t;

  typedef struct packed {
    logic [AddrW-1:0] src_address;
    logic             fill_constant;
    logic             index_error;
  } out_t;

endpackage

`default_nettype wire

// File: sv/tensor_pad_source_address_core.sv
// throughput: one coordinate triple per cycle; an output stall holds the full stages only
// stages: coordinate mirroring, range check, row multiply, column multiply
// reset: pad mode constant, source sizes 1, pad counts 0, pipeline emptied
// config regs are snapshotted as effective (clamped) values on write
`default_nettype none

module tensor_pad_source_address_core #(
  parameter int unsigned MaxDim = tpsa_pkg::MaxDimDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // config write channel
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [tpsa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [tpsa_pkg::CfgDataW-1:0]  cfg_data_i,
  // coordinate input channel
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire tpsa_pkg::in_t                  in_data_i,
  // address result channel
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      tpsa_pkg::out_t                 out_data_o
);

  localparam int N = tpsa_pkg::NumDim;
  localparam int DW = tpsa_pkg::DimW;
  localparam int CW = tpsa_pkg::CoordW;
  localparam int RW = tpsa_pkg::RelW;
  localparam int AW = tpsa_pkg::AddrW;
  localparam int RoW = tpsa_pkg::RowW;

  // ---------------------------------------------------------------------------
  // configuration: effective sizes and pads are stored already clamped
  // ---------------------------------------------------------------------------
  logic [tpsa_pkg::ModeW-1:0] mode_q;
  logic [DW-1:0]              size_q [N];
  logic [DW-1:0]              pad_q  [N];
  logic [DW-1:0]              eff_size;
  logic [DW-1:0]              eff_pad;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    // zero size acts as one, anything above the max dimension saturates
    if (cfg_data_i == '0) begin
      eff_size = DW'(1);
    end else if (32'(cfg_data_i) > MaxDim) begin
      eff_size = DW'(MaxDim);
    end else begin
      eff_size = cfg_data_i;
    end
    if (32'(cfg_data_i) > MaxDim) begin
      eff_pad = DW'(MaxDim);
    end else begin
      eff_pad = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tpsa_pkg::ModeConst;
      for (int i = 0; i < N; i++) begin
        size_q[i] <= DW'(1);
        pad_q[i]  <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tpsa_pkg::RegPadMode:    mode_q    <= cfg_data_i[tpsa_pkg::ModeW-1:0];
        tpsa_pkg::RegSrcSize0:   size_q[0] <= eff_size;
        tpsa_pkg::RegSrcSize1:   size_q[1] <= eff_size;
        tpsa_pkg::RegSrcSize2:   size_q[2] <= eff_size;
        tpsa_pkg::RegPadBegin0:  pad_q[0]  <= eff_pad;
        tpsa_pkg::RegPadBegin1:  pad_q[1]  <= eff_pad;
        tpsa_pkg::RegPadBegin2:  pad_q[2]  <= eff_pad;
        default: ; // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: mirror each coordinate into the source by pad mode
  // ---------------------------------------------------------------------------
  logic [CW-1:0]        dst [N];
  logic signed [RW-1:0] rel_d [N];
  logic                 fill_d [N];
  logic signed [RW-1:0] rel_q [N];
  logic                 fill1_q;

  assign dst[0] = in_data_i.dst_coord_0;
  assign dst[1] = in_data_i.dst_coord_1;
  assign dst[2] = in_data_i.dst_coord_2;

  always_comb begin
    logic signed [RW-1:0] d_s, p_s, s_s, sh;
    logic                 lead, trail;
    for (int i = 0; i < N; i++) begin
      d_s = signed'(RW'(dst[i]));
      p_s = signed'(RW'(pad_q[i]));
      s_s = signed'(RW'(size_q[i]));
      sh  = (mode_q == tpsa_pkg::ModeSymmetric) ? RW'(1) : RW'(0);
      lead  = d_s < p_s;
      trail = d_s >= (p_s + s_s);
      fill_d[i] = 1'b0;
      case (mode_q)
        tpsa_pkg::ModeConst: begin
          fill_d[i] = lead || trail;
          rel_d[i]  = d_s - p_s;
        end
        tpsa_pkg::ModeEdge: begin
          if (lead)       rel_d[i] = '0;
          else if (trail) rel_d[i] = s_s - RW'(1);
          else            rel_d[i] = d_s - p_s;
        end
        default: begin
          // reflect excludes the edge element, symmetric repeats it
          if (lead)       rel_d[i] = p_s - d_s - sh;
          else if (trail) rel_d[i] = (s_s <<< 1) + p_s - RW'(2) + sh - d_s;
          else            rel_d[i] = d_s - p_s;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      for (int i = 0; i < N; i++) rel_q[i] <= rel_d[i];
      fill1_q <= fill_d[0] || fill_d[1] || fill_d[2];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: range check of mirrored coordinates
  // ---------------------------------------------------------------------------
  logic          mirror_mode;
  logic          oob [N];
  logic [DW-1:0] crd_q [N];
  logic          fill2_q, err2_q;

  assign mirror_mode = (mode_q == tpsa_pkg::ModeReflect) ||
                       (mode_q == tpsa_pkg::ModeSymmetric);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      oob[i] = mirror_mode &&
               (rel_q[i][RW-1] || (rel_q[i][RW-2:0] >= (RW-1)'(size_q[i])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      for (int i = 0; i < N; i++) begin
        crd_q[i] <= (oob[i] || fill1_q) ? '0 : rel_q[i][DW-1:0];
      end
      fill2_q <= fill1_q;
      err2_q  <= oob[0] || oob[1] || oob[2];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: row offset c0 * size1 + c1
  // ---------------------------------------------------------------------------
  logic [RoW-1:0] row_q;
  logic [DW-1:0]  col_q;
  logic           fill3_q, err3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      row_q   <= (RoW'(crd_q[0]) * RoW'(size_q[1])) + RoW'(crd_q[1]);
      col_q   <= crd_q[2];
      // an error wins over fill
      fill3_q <= fill2_q && !err2_q;
      err3_q  <= err2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: linear address row * size2 + c2 into the output register
  // ---------------------------------------------------------------------------
  logic [RoW+DW-1:0] lin;
  tpsa_pkg::out_t    out_q;

  assign lin = (RoW+DW)'(row_q) * (RoW+DW)'(size_q[2]) + (RoW+DW)'(col_q);

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      out_q.src_address   <= (fill3_q || err3_q) ? '0 : lin[AW-1:0];
      out_q.fill_constant <= fill3_q;
      out_q.index_error   <= err3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // fill and error flags exclude each other
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.fill_constant && out_data_o.index_error))
    else $error("fill and error flagged together");

  // a flagged element carries a zero address
  a_flag_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.fill_constant || out_data_o.index_error))
      |-> (out_data_o.src_address == '0))
    else $error("flagged element with nonzero address");

  // fill only in constant mode
  a_fill_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fill_constant) |-> (mode_q == tpsa_pkg::ModeConst))
    else $error("fill outside constant mode");

  // errors only in reflect or symmetric mode
  a_err_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.index_error)
      |-> (mode_q == tpsa_pkg::ModeReflect || mode_q == tpsa_pkg::ModeSymmetric))
    else $error("index error outside mirror modes");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tensor_pad_source_address_core_tb.sv
// self-checking testbench of tensor_pad_source_address_core: directed and random coordinates
// under changing pad settings, checked against an in-bench address predictor
// depends on tpsa_pkg and tensor_pad_source_address_core
`default_nettype none

module tensor_pad_source_address_core_tb;

  localparam int IdxW = tpsa_pkg::CfgIdxW;
  localparam int DataW = tpsa_pkg::CfgDataW;
  localparam int CrdW = tpsa_pkg::CoordW;
  localparam int NDim = tpsa_pkg::NumDim;
  localparam int MaxDimTb = tpsa_pkg::MaxDimDefault;

  // run shape
  localparam int RandPhases = 12;
  localparam int CoordsPerPhase = 78;
  localparam int CalmTail = 60;       // last transfers run with no idling on either side
  localparam int HoldAtResult = 300;  // receiver holds off once after this many results
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 10;   // pipeline is 4 deep, a few extra for safety
  localparam int CycleLimit = 400000;

  // index past the register list, writes to it must be ignored
  localparam logic [IdxW-1:0] RegUnused = 3'd7;

  typedef enum logic [1:0] {OpCoord, OpCfg, OpSettle} stim_kind_e;

  typedef struct {
    stim_kind_e           kind;
    tpsa_pkg::in_t        coord;
    logic [IdxW-1:0]      idx;
    logic [DataW-1:0]     data;
  } stim_op_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IdxW-1:0]      cfg_index = '0;
  logic [DataW-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  tpsa_pkg::in_t        in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  tpsa_pkg::out_t       out_data;

  tensor_pad_source_address_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // pending stimulus and expected results
  stim_op_t       coord_todo_q[$];
  tpsa_pkg::out_t addr_expect_q[$];

  int coords_total = 0;
  int coords_sent = 0;
  int results_seen = 0;
  int n_errors = 0;
  int cycle_cnt = 0;

  // mirrored copy of the block's registers, as last written
  logic [tpsa_pkg::ModeW-1:0] mode_m = tpsa_pkg::ModeConst;
  logic [DataW-1:0] size_m [NDim] = '{13'd1, 13'd1, 13'd1};
  logic [DataW-1:0] padb_m [NDim] = '{13'd0, 13'd0, 13'd0};

  // a zero extent counts as one, anything above the max dimension saturates
  function automatic longint extent_eff(logic [DataW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDimTb) return MaxDimTb;
    return longint'(v);
  endfunction

  function automatic longint pad_eff(logic [DataW-1:0] v);
    if (v > MaxDimTb) return MaxDimTb;
    return longint'(v);
  endfunction

  function automatic void write_register(logic [IdxW-1:0] idx, logic [DataW-1:0] data);
    case (idx)
      tpsa_pkg::RegPadMode:   mode_m = data[tpsa_pkg::ModeW-1:0];
      tpsa_pkg::RegSrcSize0:  size_m[0] = data;
      tpsa_pkg::RegSrcSize1:  size_m[1] = data;
      tpsa_pkg::RegSrcSize2:  size_m[2] = data;
      tpsa_pkg::RegPadBegin0: padb_m[0] = data;
      tpsa_pkg::RegPadBegin1: padb_m[1] = data;
      tpsa_pkg::RegPadBegin2: padb_m[2] = data;
      default: ;
    endcase
  endfunction

  // maps a padded coordinate triple back to its source element
  function automatic tpsa_pkg::out_t predict_source(tpsa_pkg::in_t c);
    logic [CrdW-1:0] d_in [NDim];
    longint crd [NDim];
    longint ext [NDim];
    longint d, p, s, r, sh, addr;
    logic lo, hi, fill, err;
    tpsa_pkg::out_t res;
    d_in[0] = c.dst_coord_0;
    d_in[1] = c.dst_coord_1;
    d_in[2] = c.dst_coord_2;
    fill = 1'b0;
    err = 1'b0;
    // symmetric repeats the edge element, reflect skips it
    sh = (mode_m == tpsa_pkg::ModeSymmetric) ? 1 : 0;
    for (int i = 0; i < NDim; i++) begin
      d = longint'(d_in[i]);
      p = pad_eff(padb_m[i]);
      s = extent_eff(size_m[i]);
      lo = d < p;
      hi = d >= p + s;
      case (mode_m)
        tpsa_pkg::ModeConst: begin
          if (lo || hi) begin
            fill = 1'b1;
            r = 0;
          end else begin
            r = d - p;
          end
        end
        tpsa_pkg::ModeEdge: begin
          r = lo ? 0 : (hi ? s - 1 : d - p);
        end
        default: begin
          if (lo) r = p - d - sh;
          else if (hi) r = 2 * s + p - 2 + sh - d;
          else r = d - p;
          if (r < 0 || r >= s) begin
            err = 1'b1;
            r = 0;
          end
        end
      endcase
      crd[i] = r;
      ext[i] = s;
    end
    addr = (crd[0] * ext[1] + crd[1]) * ext[2] + crd[2];
    res.src_address = (fill || err) ? '0 : addr[tpsa_pkg::AddrW-1:0];
    res.fill_constant = fill && !err;
    res.index_error = err;
    return res;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  // appends one operation to the pending stimulus
  function automatic void queue_op(stim_op_t op);
    coord_todo_q = {coord_todo_q, op};
  endfunction

  // ---------------------------------------------------------------------------
  // sender: drives config writes and coordinate transfers from the queue
  // ---------------------------------------------------------------------------
  int send_gap_pct = 0;
  int send_gap_left = 0;

  always @(posedge clk_i) begin : drive_proc
    stim_op_t op;
    logic nxt_in_valid, nxt_cfg_valid;
    tpsa_pkg::in_t nxt_in_data;
    logic [IdxW-1:0] nxt_idx;
    logic [DataW-1:0] nxt_data;
    logic calm;
    if (rst_ni) begin
      // transfers completed at this edge
      if (in_valid && in_ready) begin
        addr_expect_q = {addr_expect_q, predict_source(in_data)};
        coords_sent++;
        if (coords_sent % 64 == 0) send_gap_pct = pick_idle_pct();
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);

      nxt_in_valid = in_valid && !in_ready;
      nxt_cfg_valid = cfg_valid && !cfg_ready;
      nxt_in_data = in_data;
      nxt_idx = cfg_index;
      nxt_data = cfg_data;
      calm = coords_sent >= coords_total - CalmTail;

      // pick the next thing to offer only when nothing is waiting on the bus
      if (!nxt_in_valid && !nxt_cfg_valid) begin
        if (send_gap_left > 0) begin
          send_gap_left--;
        end else if (coord_todo_q.size() > 0) begin
          op = coord_todo_q[0];
          case (op.kind)
            OpSettle: begin
              // hold back until every expected result has come out
              if (addr_expect_q.size() == 0) void'(coord_todo_q.pop_front());
            end
            OpCfg: begin
              nxt_cfg_valid = 1'b1;
              nxt_idx = op.idx;
              nxt_data = op.data;
              void'(coord_todo_q.pop_front());
            end
            default: begin
              if (!calm && $urandom_range(99) < send_gap_pct) begin
                send_gap_left = int'($urandom_range(0, 15));
              end else begin
                nxt_in_valid = 1'b1;
                nxt_in_data = op.coord;
                void'(coord_todo_q.pop_front());
              end
            end
          endcase
        end
      end

      in_valid <= nxt_in_valid;
      in_data <= nxt_in_data;
      cfg_valid <= nxt_cfg_valid;
      cfg_index <= nxt_idx;
      cfg_data <= nxt_data;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: checks each result transfer and throttles out_ready
  // ---------------------------------------------------------------------------
  int stall_pct = 0;
  int stall_left = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin : check_proc
    tpsa_pkg::out_t want;
    logic nxt_ready;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (addr_expect_q.size() == 0) begin
          $error("result with nothing expected: src_address %0h", out_data.src_address);
          n_errors++;
        end else begin
          want = addr_expect_q.pop_front();
          if (out_data.src_address !== want.src_address) begin
            $error("src_address mismatch: expected %0h, actual %0h",
                   want.src_address, out_data.src_address);
            n_errors++;
          end
          if (out_data.fill_constant !== want.fill_constant) begin
            $error("fill_constant mismatch: expected %0b, actual %0b",
                   want.fill_constant, out_data.fill_constant);
            n_errors++;
          end
          if (out_data.index_error !== want.index_error) begin
            $error("index_error mismatch: expected %0b, actual %0b",
                   want.index_error, out_data.index_error);
            n_errors++;
          end
        end
        results_seen++;
        if (results_seen % 64 == 0) stall_pct = pick_idle_pct();
        // one long hold-off so the pipeline fills and backs up into the input
        if (results_seen == HoldAtResult) hold_left = HoldCycles;
      end

      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (results_seen < coords_total - CalmTail && $urandom_range(99) < stall_pct) begin
        stall_left = int'($urandom_range(0, 15));
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  // effective sizes of the setting being generated, for aiming coordinates
  longint gen_ext [NDim];
  longint gen_pad [NDim];

  task automatic push_coord(int c0, int c1, int c2);
    stim_op_t op;
    op.kind = OpCoord;
    op.coord.dst_coord_0 = c0[CrdW-1:0];
    op.coord.dst_coord_1 = c1[CrdW-1:0];
    op.coord.dst_coord_2 = c2[CrdW-1:0];
    op.idx = '0;
    op.data = '0;
    queue_op(op);
    coords_total++;
  endtask

  task automatic push_cfg(logic [IdxW-1:0] idx, logic [DataW-1:0] data);
    stim_op_t op;
    op.kind = OpCfg;
    op.coord = '0;
    op.idx = idx;
    op.data = data;
    queue_op(op);
  endtask

  // new pad setting: wait for the pipeline to empty, then write every register
  task automatic push_setup(logic [DataW-1:0] mode_word,
                            logic [DataW-1:0] s0, logic [DataW-1:0] s1,
                            logic [DataW-1:0] s2, logic [DataW-1:0] p0,
                            logic [DataW-1:0] p1, logic [DataW-1:0] p2);
    stim_op_t op;
    op.kind = OpSettle;
    op.coord = '0;
    op.idx = '0;
    op.data = '0;
    queue_op(op);
    push_cfg(tpsa_pkg::RegPadMode, mode_word);
    push_cfg(tpsa_pkg::RegSrcSize0, s0);
    push_cfg(tpsa_pkg::RegSrcSize1, s1);
    push_cfg(tpsa_pkg::RegSrcSize2, s2);
    push_cfg(tpsa_pkg::RegPadBegin0, p0);
    push_cfg(tpsa_pkg::RegPadBegin1, p1);
    push_cfg(tpsa_pkg::RegPadBegin2, p2);
    gen_ext[0] = extent_eff(s0);
    gen_ext[1] = extent_eff(s1);
    gen_ext[2] = extent_eff(s2);
    gen_pad[0] = pad_eff(p0);
    gen_pad[1] = pad_eff(p1);
    gen_pad[2] = pad_eff(p2);
  endtask

  // half near the source and its pads, some near the borders, some anywhere
  function automatic int aim_coord(int dim);
    longint span, base, v;
    span = 2 * (gen_pad[dim] + gen_ext[dim]) + 1;
    if (span > 16383) span = 16383;
    case ($urandom_range(0, 9))
      0, 1, 2: v = longint'($urandom_range(0, 16383));
      3, 4: begin
        base = $urandom_range(0, 1) ? gen_pad[dim] : gen_pad[dim] + gen_ext[dim];
        v = base + longint'($urandom_range(0, 4)) - 2;
      end
      default: v = longint'($urandom_range(0, int'(span)));
    endcase
    if (v < 0) v = 0;
    if (v > 16383) v = 16383;
    return int'(v);
  endfunction

  function automatic logic [DataW-1:0] rand_word(int hi);
    return DataW'($urandom_range(0, hi));
  endfunction

  function automatic logic [DataW-1:0] wild_extent();
    case ($urandom_range(0, 5))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'd4097;
      4: return 13'h1fff;
      default: return rand_word(8191);
    endcase
  endfunction

  function automatic logic [DataW-1:0] wild_pad();
    case ($urandom_range(0, 4))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'h1fff;
      default: return rand_word(8191);
    endcase
  endfunction

  initial begin
    logic [DataW-1:0] mode_word;
    int mode;

    // reset setting: everything one element, constant mode
    gen_ext = '{1, 1, 1};
    gen_pad = '{0, 0, 0};
    push_coord(0, 0, 0);
    push_coord(16383, 0, 1);
    push_coord(1, 16383, 16383);

    // edge replication: leading pad, inside, far trailing pad
    push_setup(DataW'(tpsa_pkg::ModeEdge), 13'd5, 13'd7, 13'd3, 13'd2, 13'd1, 13'd4);
    push_coord(0, 0, 0);
    push_coord(4, 3, 5);
    push_coord(16383, 16383, 16383);

    // reflect: mirror on both sides, one step past the mirrored range gives an error
    push_setup(DataW'(tpsa_pkg::ModeReflect), 13'd4, 13'd4, 13'd4, 13'd3, 13'd3, 13'd3);
    push_cfg(RegUnused, 13'h1555);
    push_coord(0, 3, 6);
    push_coord(3, 4, 10);
    push_coord(7, 8, 9);

    // symmetric: edge element repeated, overrun past the mirror is an error
    push_setup(DataW'(tpsa_pkg::ModeSymmetric), 13'd4, 13'd4, 13'd4, 13'd4, 13'd4, 13'd4);
    push_coord(0, 4, 7);
    push_coord(8, 11, 12);

    // zero size and oversized extents and pads, mode word with upper bits set
    push_setup(13'h1ffd, 13'd0, 13'h1fff, 13'd4096, 13'h1fff, 13'd0, 13'd4096);
    push_cfg(RegUnused, 13'h0aaa);
    push_coord(0, 0, 0);
    push_coord(16383, 16383, 16383);
    push_coord(4096, 4095, 8191);

    // largest source: top address, then one step into the trailing pad
    push_setup(DataW'(tpsa_pkg::ModeConst), 13'd4096, 13'd4096, 13'd4096,
               13'd0, 13'd0, 13'd0);
    push_coord(4095, 4095, 4095);
    push_coord(4096, 0, 0);
    push_coord(0, 4095, 4096);

    // random phases, each with its own pad setting
    for (int ph = 0; ph < RandPhases; ph++) begin
      mode = (ph < 4) ? ph : int'($urandom_range(0, 3));
      mode_word = {11'($urandom_range(0, 2047)), 2'(mode)};
      if (ph == 5 || ph == 9) begin
        push_setup(mode_word, wild_extent(), wild_extent(), wild_extent(),
                   wild_pad(), wild_pad(), wild_pad());
      end else begin
        push_setup(mode_word, rand_word(9), rand_word(9), rand_word(9),
                   rand_word(10), rand_word(10), rand_word(10));
      end
      if ($urandom_range(0, 2) == 0) push_cfg(RegUnused, rand_word(8191));
      for (int k = 0; k < CoordsPerPhase; k++) begin
        push_coord(aim_coord(0), aim_coord(1), aim_coord(2));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // everything offered, accepted and answered
    while (coord_todo_q.size() != 0 || in_valid || cfg_valid || addr_expect_q.size() != 0)
      @(posedge clk_i);
    // give a stray extra result the chance to show up
    repeat (SettleCycles) @(posedge clk_i);

    if (n_errors == 0 && addr_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
